// ===== rtl/rrts_pkg.sv =====
// rrts_pkg: shared types and constants for the round-robin time-slice scheduler
// no dependencies
`default_nettype none
package rrts_pkg;
  localparam int unsigned TimeW  = 21;
  localparam int unsigned InW    = 16;
  localparam int unsigned WtW    = 29;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned SliceW = 8;
  localparam int unsigned QuoW   = 30;
  localparam logic [SliceW-1:0] SliceReset = 8'd2;

  typedef struct packed {
    logic [InW-1:0] arrival_time;
    logic [InW-1:0] service_time;
    logic           last_job;
  } job_t;

  typedef struct packed {
    logic [IdxW-1:0] job_index;
    logic [TimeW-1:0] finish_time;
    logic [TimeW-1:0] turnaround;
    logic [WtW-1:0] weighted_turnaround;
    logic last_record;
  } rec_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_DISPATCH, ST_RUN, ST_PLACE, ST_DIV, ST_OUT
  } state_e;

  // control from the sequencer to each cell of the queue row
  typedef struct packed {
    logic load;       // stable insert of a new job by arrival
    logic pop;        // shift the whole row toward the head
    logic place;      // reinsert the preempted job by current time
    logic [IdxW-1:0] job;
    logic [InW-1:0] arr;
    logic [TimeW-1:0] now;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/rrts_if.sv =====
// rrts_if: valid/ready channel carrying one payload
// depends on nothing
`default_nettype none
interface rrts_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rrts_cell.sv =====
// rrts_cell: one entry of the ready-order row, holds a job index and its arrival
// depends on rrts_pkg
`default_nettype none
module rrts_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire rrts_pkg::cell_ctl_t     ctl_i,
  input  wire logic                    prev_valid_i,
  input  wire logic                    prev_goes_i,   // left neighbor is before the slot
  input  wire logic [rrts_pkg::IdxW-1:0] prev_job_i,
  input  wire logic [rrts_pkg::InW-1:0]  prev_arr_i,
  input  wire logic                    next_valid_i,
  input  wire logic [rrts_pkg::IdxW-1:0] next_job_i,
  input  wire logic [rrts_pkg::InW-1:0]  next_arr_i,
  output logic                         valid_o,
  output logic                         goes_o,
  output logic [rrts_pkg::IdxW-1:0]    job_o,
  output logic [rrts_pkg::InW-1:0]     arr_o
);
  import rrts_pkg::*;
  logic            valid_q, valid_d;
  logic [IdxW-1:0] job_q, job_d;
  logic [InW-1:0]  arr_q, arr_d;
  logic            stay;

  // this entry stays ahead of the new one
  always_comb begin
    if (ctl_i.load) stay = valid_q && (arr_q <= ctl_i.arr);
    else stay = valid_q && ({5'd0, arr_q} <= ctl_i.now);
  end
  assign goes_o = stay;

  always_comb begin
    valid_d = valid_q;
    job_d   = job_q;
    arr_d   = arr_q;
    if (ctl_i.pop) begin
      valid_d = next_valid_i;
      job_d   = next_job_i;
      arr_d   = next_arr_i;
    end else if (ctl_i.load || ctl_i.place) begin
      if (!stay) begin
        // first slot past the staying prefix takes the job, the rest shift right
        if (prev_goes_i) begin
          valid_d = 1'b1;
          job_d   = ctl_i.job;
          arr_d   = ctl_i.arr;
        end else begin
          valid_d = prev_valid_i;
          job_d   = prev_job_i;
          arr_d   = prev_arr_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    arr_q <= arr_d;
  end
  assign valid_o = valid_q;
  assign job_o   = job_q;
  assign arr_o   = arr_q;
endmodule
`default_nettype wire

// ===== rtl/round_robin_time_slice_scheduler.sv =====
// round_robin_time_slice_scheduler: top level, sequencer, job stores, divider
// depends on rrts_pkg, rrts_if, rrts_cell
//
// channel  dir  payload
// job_i    in   arrival_time, service_time, last_job
// cfg_i    in   time_slice
// rec_o    out  job_index, finish_time, turnaround, weighted_turnaround, last_record
//
// jobs are taken only while loading; the final job starts the run
// each dispatch runs the head job for at most the slice of time units,
// and a preempted job is requeued by current time before the next dispatch
// each completion runs the divider, then the record waits for its transfer;
// an emptied row returns to loading
// no job is taken during a run; a stalled record holds the sequencer
// reset clears the row valid bits, counts and time; stores need no reset
`default_nettype none
module round_robin_time_slice_scheduler #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rrts_if.sink      job_i,
  rrts_if.sink      cfg_i,
  rrts_if.source    rec_o
);
  import rrts_pkg::*;
  localparam int unsigned Cap = (MAX_JOBS < 16) ? MAX_JOBS : 16;
  localparam int unsigned CntW = IdxW + 1;

  state_e state_q, state_d;
  logic [SliceW-1:0] slice_q;
  logic [CntW-1:0] qlen_q, qlen_d, done_q, total_q;
  logic [TimeW-1:0] now_q, now_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic [SliceW-1:0] sl_q, sl_d;
  logic [InW-1:0] arr_mem [16];
  logic [InW-1:0] srv_mem [16];
  logic [InW-1:0] cnt_mem [16];
  logic [InW-1:0] cur_arr_q, cur_srv_q, cur_cnt_q, cur_cnt_d;
  logic [QuoW+InW:0] rem_q;
  logic [QuoW-1:0] quo_q;
  logic [4:0] dstep_q;
  logic [TimeW-1:0] ta_q;
  rec_t rec_q;
  logic out_v_q;
  cell_ctl_t ctl;
  wire [Cap+1:0] cv;
  wire [Cap:0] cg;
  wire [IdxW-1:0] cj [Cap+2];
  wire [InW-1:0] ca [Cap+2];

  wire [InW-1:0] in_srv = (job_i.data.service_time == '0) ? 16'd1 : job_i.data.service_time;
  wire full = (qlen_q == CntW'(Cap));
  assign job_i.ready = (state_q == ST_LOAD);
  assign cfg_i.ready = 1'b1;
  wire job_x = job_i.valid && job_i.ready;

  assign cv[0] = 1'b1; assign cg[0] = 1'b1; assign cj[0] = ctl.job; assign ca[0] = ctl.arr;
  assign cv[Cap+1] = 1'b0; assign cj[Cap+1] = '0; assign ca[Cap+1] = '0;
  for (genvar g = 0; g < Cap; g++) begin : g_row
    rrts_cell u_cell (.clk_i, .rst_ni, .ctl_i(ctl),
      .prev_valid_i(cv[g]), .prev_goes_i(cg[g]), .prev_job_i(cj[g]), .prev_arr_i(ca[g]),
      .next_valid_i(cv[g+2]), .next_job_i(cj[g+2]), .next_arr_i(ca[g+2]),
      .valid_o(cv[g+1]), .goes_o(cg[g+1]), .job_o(cj[g+1]), .arr_o(ca[g+1]));
  end

  always_comb begin
    state_d = state_q; qlen_d = qlen_q; now_d = now_q; cur_d = cur_q; sl_d = sl_q;
    cur_cnt_d = cur_cnt_q;
    ctl = '0;
    ctl.now = now_q;
    ctl.job = qlen_q[IdxW-1:0];
    ctl.arr = job_i.data.arrival_time;
    unique case (state_q)
      ST_LOAD: if (job_x) begin
        if (!full) begin ctl.load = 1'b1; qlen_d = qlen_q + 1'b1; end
        if (job_i.data.last_job) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: if (!cv[1]) begin
        state_d = ST_LOAD; qlen_d = '0; now_d = '0; cur_d = '0;
      end else begin
        ctl.pop = 1'b1; cur_d = cj[1]; sl_d = '0;
        if (now_q < {5'd0, ca[1]}) now_d = {5'd0, ca[1]};
        state_d = ST_RUN;
      end
      ST_RUN: begin
        cur_cnt_d = cur_cnt_q + 1'b1; now_d = now_q + 1'b1; sl_d = sl_q + 1'b1;
        if (cur_cnt_d >= cur_srv_q) state_d = ST_DIV;
        else if (sl_d >= ((slice_q == 0) ? 8'd1 : slice_q)) state_d = ST_PLACE;
      end
      ST_PLACE: begin
        ctl.place = 1'b1; ctl.job = cur_q; ctl.arr = cur_arr_q; state_d = ST_DISPATCH;
      end
      ST_DIV: if (dstep_q == 5'(QuoW - 1)) state_d = ST_OUT;
      ST_OUT: if (!out_v_q) state_d = ST_DISPATCH;
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; slice_q <= SliceReset; qlen_q <= '0; now_q <= '0;
      cur_q <= '0; sl_q <= '0; done_q <= '0; total_q <= '0; dstep_q <= '0; out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; qlen_q <= qlen_d; now_q <= now_d; cur_q <= cur_d; sl_q <= sl_d;
      if (cfg_i.valid) slice_q <= cfg_i.data;
      if (state_q == ST_LOAD && job_x && job_i.data.last_job) begin
        total_q <= qlen_d; done_q <= '0;
      end
      if (state_q == ST_DIV) dstep_q <= dstep_q + 1'b1; else dstep_q <= '0;
      if (state_q == ST_DIV && state_d == ST_OUT) begin
        out_v_q <= 1'b1; done_q <= done_q + 1'b1;
      end else if (rec_o.ready) out_v_q <= 1'b0;
    end
  end

  // store reads are registered at dispatch; run count written back on preemption
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD && job_x && !full) begin
      arr_mem[qlen_q[IdxW-1:0]] <= job_i.data.arrival_time;
      srv_mem[qlen_q[IdxW-1:0]] <= in_srv;
      cnt_mem[qlen_q[IdxW-1:0]] <= '0;
    end
    if (state_q == ST_DISPATCH) begin
      cur_arr_q <= arr_mem[cj[1]]; cur_srv_q <= srv_mem[cj[1]]; cur_cnt_q <= cnt_mem[cj[1]];
    end else cur_cnt_q <= cur_cnt_d;
    if (state_q == ST_PLACE) cnt_mem[cur_q] <= cur_cnt_q;
    // restoring divider, one quotient bit per cycle
    if (state_q == ST_RUN) begin
      ta_q <= now_d - {5'd0, cur_arr_q};
      rem_q <= '0; quo_q <= '0;
    end else if (state_q == ST_DIV) begin
      logic [QuoW+InW:0] t;
      logic [QuoW-1:0] dv;
      dv = {1'b0, ta_q, 8'd0};
      t = {rem_q[QuoW+InW-1:0], dv[QuoW-1-dstep_q]};
      if (t >= {{(QuoW+1){1'b0}}, cur_srv_q}) begin
        rem_q <= t - {{(QuoW+1){1'b0}}, cur_srv_q}; quo_q <= {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_q <= t; quo_q <= {quo_q[QuoW-2:0], 1'b0};
      end
    end
    if (state_q == ST_DIV && state_d == ST_OUT) begin
      logic [QuoW-1:0] qn;
      qn = {quo_q[QuoW-2:0], (({rem_q[QuoW+InW-1:0], 1'b0} >= {{(QuoW+1){1'b0}}, cur_srv_q}) ? 1'b1 : 1'b0)};
      rec_q.job_index <= cur_q;
      rec_q.finish_time <= now_q;
      rec_q.turnaround <= ta_q;
      rec_q.weighted_turnaround <= qn[QuoW-1] ? {WtW{1'b1}} : qn[WtW-1:0];
      rec_q.last_record <= (done_q + 1'b1 == total_q);
    end
  end

  assign rec_o.valid = out_v_q;
  assign rec_o.data  = rec_q;
endmodule
`default_nettype wire

// ===== rtl/rrts_checker.sv =====
// rrts_checker: port-level checks on the scheduler
// depends on rrts_pkg and rrts_if; bound to round_robin_time_slice_scheduler
`default_nettype none
module rrts_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           job_ready_i,
  input wire logic           rec_valid_i,
  input wire logic           rec_ready_i,
  input wire rrts_pkg::rec_t rec_data_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i && !rec_ready_i |=> rec_valid_i && $stable(rec_data_i))
    else $error("record dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) rec_valid_i |-> !job_ready_i)
    else $error("job taken during run");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_i && rec_ready_i |=> !rec_valid_i)
    else $error("record repeated");
endmodule
bind round_robin_time_slice_scheduler rrts_checker u_chk (.clk_i, .rst_ni,
  .job_ready_i(job_i.ready), .rec_valid_i(rec_o.valid), .rec_ready_i(rec_o.ready),
  .rec_data_i(rec_o.data));
`default_nettype wire

// ===== verif/schedule_checker.sv =====
// schedule_checker: predicts the round-robin schedule of every job set and
// compares the records; depends on rrts_pkg
`default_nettype none
module schedule_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  input  wire logic           job_ready_i,
  input  wire rrts_pkg::job_t job_data_i,
  input  wire logic           cfg_valid_i,
  input  wire logic           cfg_ready_i,
  input  wire logic [7:0]     cfg_data_i,
  input  wire logic           rec_valid_i,
  input  wire logic           rec_ready_i,
  input  wire rrts_pkg::rec_t rec_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  import rrts_pkg::*;
  localparam int unsigned JobCap = 16;

  logic [15:0] arrival_q [JobCap];
  logic [15:0] service_q [JobCap];
  logic [3:0]  order_q [JobCap];
  int unsigned loaded_q;
  logic [7:0]  slice_q;
  rec_t        expected_records [$];

  assign pending_o = expected_records.size();

  // runs the loaded set to completion and queues one record per finished job
  task automatic schedule_set();
    int unsigned q [JobCap];
    int unsigned ran [JobCap];
    int unsigned qlen, now, slice, j, run, pos, k, done;
    longint unsigned ta, wt;
    rec_t r;
    qlen = loaded_q;
    now = 0;
    done = 0;
    for (k = 0; k < qlen; k++) begin
      q[k] = order_q[k];
      ran[k] = 0;
    end
    slice = (slice_q == 0) ? 1 : slice_q;
    while (qlen > 0) begin
      j = q[0];
      for (k = 1; k < qlen; k++) q[k-1] = q[k];
      qlen--;
      if (now < arrival_q[j]) now = arrival_q[j];
      run = service_q[j] - ran[j];
      if (run > slice) run = slice;
      ran[j] += run;
      now += run;
      if (ran[j] >= service_q[j]) begin
        done++;
        ta = now - arrival_q[j];
        wt = (ta << 8) / service_q[j];
        if (wt > 64'h1FFF_FFFF) wt = 64'h1FFF_FFFF;
        r.job_index = j[3:0];
        r.finish_time = now[TimeW-1:0];
        r.turnaround = ta[TimeW-1:0];
        r.weighted_turnaround = wt[WtW-1:0];
        r.last_record = (done == loaded_q);
        expected_records.push_back(r);
      end else begin
        pos = 0;
        while (pos < qlen && now >= arrival_q[q[pos]]) pos++;
        for (k = qlen; k > pos; k--) q[k] = q[k-1];
        q[pos] = j;
        qlen++;
      end
    end
    loaded_q = 0;
  endtask

  task automatic load_job(job_t jb);
    int unsigned pos, k;
    logic [15:0] svc;
    if (loaded_q < JobCap) begin
      svc = (jb.service_time == 0) ? 16'd1 : jb.service_time;
      arrival_q[loaded_q] = jb.arrival_time;
      service_q[loaded_q] = svc;
      pos = 0;
      while (pos < loaded_q && arrival_q[order_q[pos]] <= jb.arrival_time) pos++;
      for (k = loaded_q; k > pos; k--) order_q[k] = order_q[k-1];
      order_q[pos] = loaded_q[3:0];
      loaded_q++;
    end
    if (jb.last_job) schedule_set();
  endtask

  task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
    if (fail_count_o < 10)
      $display("mismatch %s: expected %0d got %0d", what, want, got);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rec_t want;
    if (!rst_ni) begin
      loaded_q = 0;
      slice_q = SliceReset;
      fail_count_o = 0;
      expected_records.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) slice_q = cfg_data_i;
      if (job_valid_i && job_ready_i) load_job(job_data_i);
      if (rec_valid_i && rec_ready_i) begin
        if (expected_records.size() == 0) begin
          note_mismatch("unexpected record, job_index", 0, rec_data_i.job_index);
        end else begin
          want = expected_records.pop_front();
          if (want.job_index != rec_data_i.job_index)
            note_mismatch("job_index", want.job_index, rec_data_i.job_index);
          if (want.finish_time != rec_data_i.finish_time)
            note_mismatch("finish_time", want.finish_time, rec_data_i.finish_time);
          if (want.turnaround != rec_data_i.turnaround)
            note_mismatch("turnaround", want.turnaround, rec_data_i.turnaround);
          if (want.weighted_turnaround != rec_data_i.weighted_turnaround)
            note_mismatch("weighted_turnaround", want.weighted_turnaround,
                          rec_data_i.weighted_turnaround);
          if (want.last_record != rec_data_i.last_record)
            note_mismatch("last_record", want.last_record, rec_data_i.last_record);
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// testbench: clock, reset and stimulus for round_robin_time_slice_scheduler
// depends on rrts_pkg, rrts_if and schedule_checker
`default_nettype none
module testbench;
  import rrts_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned fail_count, pending, jobs_sent, hold_left;
  int unsigned phase;
  bit          hold_done;

  rrts_if #(.T(job_t))        job_if ();
  rrts_if #(.T(logic [7:0]))  cfg_if ();
  rrts_if #(.T(rec_t))        rec_if ();

  round_robin_time_slice_scheduler i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job_if),
    .cfg_i  (cfg_if),
    .rec_o  (rec_if)
  );

  schedule_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_if.valid),
    .job_ready_i  (job_if.ready),
    .job_data_i   (job_if.data),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_data_i   (cfg_if.data),
    .rec_valid_i  (rec_if.valid),
    .rec_ready_i  (rec_if.ready),
    .rec_data_i   (rec_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #60_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // phases: sender idles 18 / receiver 64, then swapped, then no idling
  assign phase = (jobs_sent < 140) ? 0 : (jobs_sent < 280) ? 1 : 2;

  // receiver, with one long hold-off while jobs keep coming
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      rec_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && jobs_sent >= 300 && pending > 0) begin
      rec_if.ready <= 1'b0;
      hold_left <= 800;
      hold_done <= 1'b1;
    end else begin
      case (phase)
        0: rec_if.ready <= ($urandom_range(0, 99) >= 64);
        1: rec_if.ready <= ($urandom_range(0, 99) >= 18);
        default: rec_if.ready <= 1'b1;
      endcase
    end
  end

  task automatic send_job(input logic [15:0] arr, input logic [15:0] svc, input bit last);
    bit ok;
    int unsigned pct;
    pct = (phase == 0) ? 18 : (phase == 1) ? 64 : 0;
    if ($urandom_range(0, 99) < pct) begin
      job_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    job_if.valid <= 1'b1;
    job_if.data <= '{arrival_time: arr, service_time: svc, last_job: last};
    do begin
      @(negedge clk_i);
      ok = job_if.ready;
      @(posedge clk_i);
    end while (!ok);
    jobs_sent++;
  endtask

  // only while idle: every record in, then a pause for the block to settle
  task automatic write_slice(input logic [7:0] value);
    bit ok;
    job_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do begin
      @(negedge clk_i);
      ok = cfg_if.ready;
      @(posedge clk_i);
    end while (!ok);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int unsigned n, k, sets;
    logic [7:0] slice;
    logic [15:0] arr, svc;
    job_if.valid = 1'b0;
    job_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    rec_if.ready = 1'b0;
    jobs_sent = 0;
    hold_left = 0;
    hold_done = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default slice, ties in arrival, zero service time
    send_job(16'd5, 16'd3, 1'b0);
    send_job(16'd0, 16'd4, 1'b0);
    send_job(16'd5, 16'd1, 1'b0);
    send_job(16'd0, 16'd0, 1'b0);
    send_job(16'd2, 16'd6, 1'b1);
    // zero slice, late arrival forces a time jump
    write_slice(8'd0);
    send_job(16'd0, 16'd2, 1'b0);
    send_job(16'hFFFF, 16'd1, 1'b0);
    send_job(16'd3, 16'd5, 1'b1);
    // widest slice, longest service
    write_slice(8'd255);
    send_job(16'd0, 16'hFFFF, 1'b0);
    send_job(16'd10, 16'd300, 1'b1);
    // overfull set: jobs past sixteen are dropped
    write_slice(8'd1);
    for (k = 0; k < 18; k++) send_job(16'(k % 3), 16'(1 + k % 3), k == 17);

    slice = 8'd1;
    sets = 0;
    while (jobs_sent < 410) begin
      if (sets % 3 == 0) begin
        case ($urandom_range(0, 4))
          0: slice = 8'd1;
          1: slice = 8'd255;
          2: slice = 8'd0;
          default: slice = 8'($urandom_range(2, 12));
        endcase
        write_slice(slice);
      end
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
      for (k = 0; k < n; k++) begin
        arr = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
        if (slice >= 64 && $urandom_range(0, 49) == 0) svc = 16'($urandom);
        else if ($urandom_range(0, 29) == 0) svc = 16'd0;
        else svc = 16'($urandom_range(1, 40));
        send_job(arr, svc, k == n - 1);
      end
      sets++;
    end
    job_if.valid <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
